// File: sv/block_decomposed_range_sum_macros.svh
// Assertion helpers; expect clk and rst_n in the using scope.
`ifndef BLOCK_DECOMPOSED_RANGE_SUM_MACROS_SVH
`define BLOCK_DECOMPOSED_RANGE_SUM_MACROS_SVH

// same-cycle implication
`define BRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BRS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("assertion failed");

`endif

// File: sv/brs_pkg.sv
package brs_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 10;
  localparam int AMT_W  = 16;
  localparam int CNT_W  = 11;
  localparam int OP_W   = 2;

  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_TAKE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic elem_we;
    logic elem_re;
    logic bs_we;
    logic bs_re;
  } store_ctl_t;

endpackage

// File: sv/brs_alu.sv
module brs_alu (
  input  logic [brs_pkg::DATA_W-1:0] a,
  input  logic [brs_pkg::DATA_W-1:0] b,
  input  logic                       sub,
  output logic [brs_pkg::DATA_W-1:0] y
);
  import brs_pkg::*;

  assign y = sub ? (a - b) : (a + b);

endmodule

// File: sv/brs_store.sv
module brs_store #(
  parameter int ELEMENTS = 1024,
  parameter int BLOCKS   = 32
) (
  input  logic                          clk,
  input  brs_pkg::store_ctl_t           ctl,
  input  logic [$clog2(ELEMENTS)-1:0]   elem_addr,
  input  logic [brs_pkg::DATA_W-1:0]    elem_wdata,
  input  logic [$clog2(BLOCKS)-1:0]     bs_addr,
  input  logic [brs_pkg::DATA_W-1:0]    bs_wdata,
  output logic [brs_pkg::DATA_W-1:0]    elem_rdata,
  output logic [brs_pkg::DATA_W-1:0]    bs_rdata
);
  import brs_pkg::*;

  logic [DATA_W-1:0] elem_mem [ELEMENTS];
  logic [DATA_W-1:0] bs_mem   [BLOCKS];
  logic [DATA_W-1:0] elem_rd_r;
  logic [DATA_W-1:0] bs_rd_r;

  always_ff @(posedge clk) begin
    if (ctl.elem_we) begin
      elem_mem[elem_addr] <= elem_wdata;
    end
    if (ctl.elem_re) begin
      elem_rd_r <= elem_mem[elem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.bs_we) begin
      bs_mem[bs_addr] <= bs_wdata;
    end
    if (ctl.bs_re) begin
      bs_rd_r <= bs_mem[bs_addr];
    end
  end

  assign elem_rdata = elem_rd_r;
  assign bs_rdata   = bs_rd_r;

endmodule

// File: sv/block_decomposed_range_sum.sv
// Point-update / range-sum store over ELEMENTS 32-bit words grouped in blocks of BLOCK_SIZE,
// with one running sum per block (BLOCKS of them). One item is worked at a time and in_ready
// is low until it is finished. After reset the store clears itself, one word per cycle, over
// addresses 0 to max(ELEMENTS, BLOCKS)-1 before the first item is taken. An add or a take
// reads the element and its block sum and writes both back, and a take, in range or not,
// then waits for out_ready; out of range, neither touches the memories. A range sum walks
// elements and whole blocks, none when empty or out of range: every step is one read of
// the element or block-sum memory, accumulated by the single 32-bit adder.
// Configuration (element_count) is accepted at any time but must only change while idle.
module block_decomposed_range_sum #(
  parameter int ELEMENTS   = 1024,
  parameter int BLOCK_SIZE = 32,
  parameter int BLOCKS     = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [brs_pkg::OP_W-1:0]    in_opcode,
  input  logic [brs_pkg::IDX_W-1:0]   in_index,
  input  logic [brs_pkg::IDX_W-1:0]   in_high_index,
  input  logic [brs_pkg::AMT_W-1:0]   in_amount,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [brs_pkg::DATA_W-1:0]  out_value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [brs_pkg::CNT_W-1:0]   cfg_element_count
);
  import brs_pkg::*;
  `include "block_decomposed_range_sum_macros.svh"

  localparam int AW    = $clog2(ELEMENTS);
  localparam int BW    = $clog2(BLOCKS);
  localparam int SH    = $clog2(BLOCK_SIZE);
  localparam int PW0   = $clog2(ELEMENTS + BLOCK_SIZE + 1);
  localparam int PW    = (PW0 > CNT_W) ? PW0 : CNT_W;
  localparam int CLR_N = (ELEMENTS > BLOCKS) ? ELEMENTS : BLOCKS;
  localparam int CW    = $clog2(CLR_N);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_DEC  = 4'd2;
  localparam logic [3:0] ST_T_WB = 4'd3;
  localparam logic [3:0] ST_T_BS = 4'd4;
  localparam logic [3:0] ST_A_EL = 4'd5;
  localparam logic [3:0] ST_A_BS = 4'd6;
  localparam logic [3:0] ST_Q    = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ELEM = 2'd1;
  localparam logic [1:0] PEND_BLK  = 2'd2;

  logic [3:0]        state_r, state_nxt;
  logic [CW-1:0]     clr_r, clr_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     hi_r, hi_nxt;
  logic [AMT_W-1:0]  amt_r, amt_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [1:0]        pend_r, pend_nxt;

  store_ctl_t        ctl;
  logic [AW-1:0]     elem_addr;
  logic [BW-1:0]     bs_addr;
  logic [DATA_W-1:0] elem_wd, bs_wd, elem_rd, bs_rd;
  logic [DATA_W-1:0] alu_a, alu_b, alu_y;
  logic              alu_sub;

  logic [PW-1:0]     cnt_act, count_ext, blk_idx, hi_clip, in_idx_ext;
  logic              idx_ok, blk_ok, aligned, c_part, c_blk, c_tail;
  logic              take_oob;

  assign count_ext  = PW'(count_r);
  assign cnt_act    = (count_ext > PW'(ELEMENTS)) ? PW'(ELEMENTS) : count_ext;
  assign in_idx_ext = {{(PW-IDX_W){1'b0}}, in_index};
  assign idx_ok     = pos_r < cnt_act;
  assign hi_clip    = (hi_r >= cnt_act) ? (cnt_act - PW'(1)) : hi_r;
  assign blk_idx    = pos_r >> SH;
  assign blk_ok     = blk_idx < PW'(BLOCKS);
  assign aligned    = (pos_r[SH-1:0] == '0);
  assign c_part     = (pos_r < hi_r) && !aligned;
  assign c_blk      = (pos_r + PW'(BLOCK_SIZE)) <= (hi_r + PW'(1));
  assign c_tail     = pos_r <= hi_r;

  assign take_oob = in_valid && in_ready && (in_opcode == OP_TAKE) && (in_idx_ext >= cnt_act);

  assign elem_addr = (state_r == ST_CLR) ? clr_r[AW-1:0] : pos_r[AW-1:0];
  assign bs_addr   = (state_r == ST_CLR) ? clr_r[BW-1:0] : blk_idx[BW-1:0];

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_value = acc_r;
  assign cfg_ready = 1'b1;

  brs_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  brs_store #(
    .ELEMENTS (ELEMENTS),
    .BLOCKS   (BLOCKS)
  ) u_store (
    .clk        (clk),
    .ctl        (ctl),
    .elem_addr  (elem_addr),
    .elem_wdata (elem_wd),
    .bs_addr    (bs_addr),
    .bs_wdata   (bs_wd),
    .elem_rdata (elem_rd),
    .bs_rdata   (bs_rd)
  );

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    pos_nxt   = pos_r;
    hi_nxt    = hi_r;
    amt_nxt   = amt_r;
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    ctl       = '0;
    elem_wd   = '0;
    bs_wd     = '0;
    alu_a     = acc_r;
    alu_b     = '0;
    alu_sub   = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        ctl.elem_we = ({1'b0, clr_r} < (CW+1)'(ELEMENTS));
        ctl.bs_we   = ({1'b0, clr_r} < (CW+1)'(BLOCKS));
        clr_nxt     = clr_r + CW'(1);
        if (clr_r == CW'(CLR_N - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          pos_nxt   = in_idx_ext;
          hi_nxt    = {{(PW-IDX_W){1'b0}}, in_high_index};
          amt_nxt   = in_amount;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        unique case (op_r)
          OP_TAKE: begin
            acc_nxt = '0;
            if (idx_ok) begin
              ctl.elem_re = 1'b1;
              ctl.bs_re   = blk_ok;
              state_nxt   = ST_T_WB;
            end else begin
              state_nxt = ST_OUT;
            end
          end
          OP_ADD: begin
            if (idx_ok) begin
              ctl.elem_re = 1'b1;
              ctl.bs_re   = blk_ok;
              state_nxt   = ST_A_EL;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          OP_QUERY: begin
            acc_nxt  = '0;
            hi_nxt   = hi_clip;
            pend_nxt = PEND_NONE;
            if (idx_ok && (pos_r <= hi_clip)) begin
              state_nxt = ST_Q;
            end else begin
              state_nxt = ST_OUT;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_T_WB: begin
        ctl.elem_we = 1'b1;
        acc_nxt     = elem_rd;
        state_nxt   = blk_ok ? ST_T_BS : ST_OUT;
      end
      ST_T_BS: begin
        alu_a     = bs_rd;
        alu_b     = acc_r;
        alu_sub   = 1'b1;
        ctl.bs_we = 1'b1;
        bs_wd     = alu_y;
        state_nxt = ST_OUT;
      end
      ST_A_EL: begin
        alu_a       = elem_rd;
        alu_b       = {{(DATA_W-AMT_W){1'b0}}, amt_r};
        ctl.elem_we = 1'b1;
        elem_wd     = alu_y;
        state_nxt   = blk_ok ? ST_A_BS : ST_IDLE;
      end
      ST_A_BS: begin
        alu_a     = bs_rd;
        alu_b     = {{(DATA_W-AMT_W){1'b0}}, amt_r};
        ctl.bs_we = 1'b1;
        bs_wd     = alu_y;
        state_nxt = ST_IDLE;
      end
      ST_Q: begin
        // accumulate last cycle's read, issue the next one
        alu_a = acc_r;
        case (pend_r)
          PEND_ELEM: alu_b = elem_rd;
          PEND_BLK:  alu_b = bs_rd;
          default:   alu_b = '0;
        endcase
        acc_nxt = alu_y;
        if (c_part || (!c_blk && c_tail)) begin
          ctl.elem_re = 1'b1;
          pend_nxt    = PEND_ELEM;
          pos_nxt     = pos_r + PW'(1);
        end else if (c_blk) begin
          ctl.bs_re = blk_ok;
          pend_nxt  = blk_ok ? PEND_BLK : PEND_NONE;
          pos_nxt   = pos_r + PW'(BLOCK_SIZE);
        end else begin
          pend_nxt  = PEND_NONE;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
      count_r <= CNT_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_valid) begin
        count_r <= cfg_element_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    pos_r  <= pos_nxt;
    hi_r   <= hi_nxt;
    amt_r  <= amt_nxt;
    acc_r  <= acc_nxt;
    pend_r <= pend_nxt;
  end

  `BRS_ASSERT_IMP(a_one_item, out_valid, !in_ready)
  `BRS_ASSERT_NXT(a_add_silent, in_valid && in_ready && (in_opcode == OP_ADD), !out_valid)
  `BRS_ASSERT_NXT(a_take_oob, take_oob, ##1 (out_valid && (out_value == '0)))

endmodule
